### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked assertions on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// Check that a condition in one cycle implies another in the next.
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

### hw/rtl/pmst_pkg.sv
// ----------------------------------------------------------------------------
// pmst_pkg
// Types and constants shared by the motif scan modules.
// ----------------------------------------------------------------------------
package pmst_pkg;

  localparam int MAX_MOTIF_WIDTH = 32;
  localparam int MAX_KMER_ORDER  = 3;
  localparam int MAX_ALPHABET    = 4;
  localparam int COL_W           = 5;
  localparam int ROW_W           = 6;
  localparam int ADDR_W          = COL_W + ROW_W;
  localparam int TABLE_DEPTH     = 2048;
  localparam int SCORE_W         = 24;
  localparam int POS_W           = 21;
  localparam int SUM_W           = 34;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [POS_W-1:0]   MAX_SEQ_LENGTH = 21'd1048576;
  localparam logic signed [SUM_W-1:0] BAD_KMER_SCORE = -34'sd999999;
  localparam logic signed [SUM_W-1:0] SUM_MAX = 34'sd2147483647;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -34'sd2147483648;

  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_KMER      = 2'd1,
    CFG_ALPHABET  = 2'd2,
    CFG_WIDTH     = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_LETTER = 1'b1
  } item_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DRAIN,
    ST_EMIT
  } back_st_e;

  typedef struct packed {
    logic               cmd;
    logic [1:0]         letter_code;
    logic               not_in_alphabet;
    logic               first_of_sequence;
    logic [4:0]         entry_column;
    logic [5:0]         entry_row;
    logic signed [23:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        sequence_number;
    logic [20:0]        start_pos;
    logic [20:0]        stop_pos;
    logic signed [31:0] window_score;
  } out_item_t;

  typedef struct packed {
    item_kind_e kind;
    in_item_t   item;
  } q_entry_t;

  typedef struct packed {
    logic valid;
    logic take;
  } q_ctrl_t;

  typedef struct packed {
    logic signed [31:0] score_threshold;
    logic [1:0]         kmer_order;
    logic [2:0]         alphabet_size;
    logic [5:0]         motif_width;
  } cfg_t;

endpackage

### hw/rtl/pwm_motif_scan_threshold_core.sv
// ----------------------------------------------------------------------------
// pwm_motif_scan_threshold_core
// Position weight matrix scan of a coded letter stream with a score threshold.
// ----------------------------------------------------------------------------
// Push matrix writes (cmd 0) and letters (cmd 1) through one queue port; hits
// come out of a result queue port. The back end takes a matrix write or a
// letter that does not complete a window in its idle state; a letter that
// completes one starts a sum over the single read port of the score table,
// read one column per cycle while a running sum accumulates; a hit that finds
// the result register full waits. A two-entry queue sits between the front end
// and the back end, and a result register holds a hit until it is popped, so
// input keeps flowing while a result waits. Write configuration only while idle.
// ----------------------------------------------------------------------------
module pwm_motif_scan_threshold_core import pmst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t     cfg_q;
  q_entry_t head;
  q_ctrl_t  qctrl;
  logic     take;

  // configuration is always ready; a transfer writes one register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_threshold <= '0;
      cfg_q.kmer_order      <= 2'd1;
      cfg_q.alphabet_size   <= 3'd4;
      cfg_q.motif_width     <= 6'd8;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_THRESHOLD: cfg_q.score_threshold <= cfg_data_i;
        CFG_KMER:      cfg_q.kmer_order      <= cfg_data_i[1:0];
        CFG_ALPHABET:  cfg_q.alphabet_size   <= cfg_data_i[2:0];
        CFG_WIDTH:     cfg_q.motif_width     <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // front end: accept and classify, queue for the back end
  pmst_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .in_i   (in_i),
    .head_o (head),
    .take_i (take),
    .ctrl_o (qctrl)
  );

  // back end: window update, column sum, threshold, result hold
  pmst_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .head_i (head),
    .ctrl_i (qctrl),
    .take_o (take),
    .empty  (empty),
    .pop    (pop),
    .out_o  (out_o)
  );

endmodule

### hw/rtl/pmst_ram.sv
// ----------------------------------------------------------------------------
// pmst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pmst_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/pmst_front.sv
// ----------------------------------------------------------------------------
// pmst_front
// Input acceptance, item classification and the short queue to the back end.
// ----------------------------------------------------------------------------
module pmst_front import pmst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t in_i,
  output q_entry_t head_o,
  input  logic     take_i,
  output q_ctrl_t  ctrl_o
);

  q_entry_t   mem_q [QUEUE_DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full    = (cnt_q == 2'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = take_i && (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // classify on entry so the back end decodes one flag
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q].kind <= in_i.cmd ? KIND_LETTER : KIND_WRITE;
      mem_q[wr_ptr_q].item <= in_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign ctrl_o.valid = (cnt_q != 2'd0);
  assign ctrl_o.take  = do_pop;

endmodule

### hw/rtl/pmst_back.sv
// ----------------------------------------------------------------------------
// pmst_back
// Window update, column-serial score sum, threshold test and result register.
// ----------------------------------------------------------------------------
module pmst_back import pmst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  q_entry_t  head_i,
  input  q_ctrl_t   ctrl_i,
  output logic      take_o,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_o
);

  back_st_e state_q, state_d;

  logic [2:0]  hist_q [MAX_KMER_ORDER];
  logic [2:0]  hist_d [MAX_KMER_ORDER];
  logic [6:0]  win_q  [MAX_MOTIF_WIDTH];
  logic [6:0]  win_d  [MAX_MOTIF_WIDTH];
  logic [POS_W-1:0] seen_q, seen_d;
  logic [15:0] seq_q, seq_d;
  logic [COL_W-1:0] col_q, col_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic        pend_q, pend_d;
  logic        pend_bad_q, pend_bad_d;
  logic        res_valid_q, res_valid_d;
  out_item_t   res_q, res_d;

  logic [1:0]  k_eff;
  logic [2:0]  a_eff;
  logic [5:0]  w_eff;
  logic        is_letter, go_sum, last_col, hit, slot_free;
  logic        ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [SCORE_W-1:0] ram_rdata;
  logic [5:0]  win_sel;
  logic [6:0]  km_rd;
  logic signed [SUM_W-1:0] sum_sat;
  logic [POS_W-1:0] start_pos;

  // clamp the registers to their working ranges
  always_comb begin
    k_eff = (cfg_i.kmer_order == 2'd0) ? 2'd1 : cfg_i.kmer_order;
    if (cfg_i.alphabet_size < 3'd2) begin
      a_eff = 3'd2;
    end else if (cfg_i.alphabet_size > 3'(MAX_ALPHABET)) begin
      a_eff = 3'(MAX_ALPHABET);
    end else begin
      a_eff = cfg_i.alphabet_size;
    end
    if (cfg_i.motif_width == 6'd0) begin
      w_eff = 6'd1;
    end else if (cfg_i.motif_width > 6'(MAX_MOTIF_WIDTH)) begin
      w_eff = 6'(MAX_MOTIF_WIDTH);
    end else begin
      w_eff = cfg_i.motif_width;
    end
  end

  assign is_letter = (head_i.kind == KIND_LETTER);
  assign take_o    = (state_q == ST_IDLE) && ctrl_i.valid;
  assign ram_we    = take_o && !is_letter;

  assign win_sel   = w_eff - 6'd1 - {1'b0, col_q};
  assign km_rd     = win_q[win_sel[COL_W-1:0]];
  assign ram_raddr = {col_q, km_rd[ROW_W-1:0]};
  assign last_col  = ({1'b0, col_q} == w_eff - 6'd1);

  pmst_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({head_i.item.entry_column, head_i.item.entry_row}),
    .wdata_i (head_i.item.entry_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (sum_q > SUM_MAX) begin
      sum_sat = SUM_MAX;
    end else if (sum_q < SUM_MIN) begin
      sum_sat = SUM_MIN;
    end else begin
      sum_sat = sum_q;
    end
    hit       = (sum_sat >= SUM_W'(cfg_i.score_threshold));
    start_pos = seen_q + POS_W'(2) - POS_W'(k_eff) - POS_W'(w_eff);
    slot_free = !res_valid_q || pop;
  end

  // datapath next values
  always_comb begin
    logic [2:0]       hist_b [MAX_KMER_ORDER];
    logic [6:0]       win_b  [MAX_MOTIF_WIDTH];
    logic [POS_W-1:0] seen_b;
    logic             first, bad, kbad;
    logic [5:0]       idx;
    logic [8:0]       prod;

    hist_d      = hist_q;
    win_d       = win_q;
    seen_d      = seen_q;
    seq_d       = seq_q;
    col_d       = col_q;
    sum_d       = sum_q;
    pend_d      = 1'b0;
    pend_bad_d  = pend_bad_q;
    res_valid_d = res_valid_q && !pop;
    res_d       = res_q;
    go_sum      = 1'b0;

    first = head_i.item.first_of_sequence;
    for (int i = 0; i < MAX_KMER_ORDER; i++) begin
      hist_b[i] = first ? 3'd0 : hist_q[i];
    end
    for (int i = 0; i < MAX_MOTIF_WIDTH; i++) begin
      win_b[i] = first ? 7'd0 : win_q[i];
    end
    seen_b = first ? '0 : seen_q;
    bad    = head_i.item.not_in_alphabet || ({1'b0, head_i.item.letter_code} >= a_eff);

    // build the k-mer from the updated history, oldest letter first
    idx  = '0;
    kbad = 1'b0;
    prod = '0;
    for (int b = MAX_KMER_ORDER - 1; b >= 0; b--) begin
      logic [2:0] h;
      h = (b == 0) ? {bad, head_i.item.letter_code} : hist_b[b-1];
      if (b < int'(k_eff)) begin
        prod = 9'(idx * a_eff) + 9'(h[1:0]);
        idx  = prod[5:0];
        kbad = kbad | h[2];
      end
    end

    if (take_o && is_letter) begin
      seq_d = seq_q + 16'(first);
      if (seen_b >= MAX_SEQ_LENGTH) begin
        hist_d = hist_b;
        win_d  = win_b;
        seen_d = seen_b;
      end else begin
        hist_d[0] = {bad, head_i.item.letter_code};
        for (int i = 1; i < MAX_KMER_ORDER; i++) begin
          hist_d[i] = hist_b[i-1];
        end
        seen_d = seen_b + POS_W'(1);
        win_d  = win_b;
        if (seen_d >= POS_W'(k_eff)) begin
          win_d[0] = {kbad, idx};
          for (int i = 1; i < MAX_MOTIF_WIDTH; i++) begin
            win_d[i] = win_b[i-1];
          end
          if (seen_d + POS_W'(1) >= POS_W'(w_eff) + POS_W'(k_eff)) begin
            go_sum = 1'b1;
            col_d  = '0;
            sum_d  = '0;
          end
        end
      end
    end

    // accumulate the column read in the previous cycle
    if (pend_q) begin
      sum_d = sum_q + (pend_bad_q ? BAD_KMER_SCORE : SUM_W'($signed(ram_rdata)));
    end

    if (state_q == ST_SUM) begin
      pend_d     = 1'b1;
      pend_bad_d = km_rd[6];
      col_d      = col_q + COL_W'(1);
    end

    if ((state_q == ST_EMIT) && hit && slot_free) begin
      res_valid_d           = 1'b1;
      res_d.sequence_number = seq_q;
      res_d.start_pos       = start_pos;
      res_d.stop_pos        = start_pos + POS_W'(w_eff) - POS_W'(1);
      res_d.window_score    = sum_sat[31:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (go_sum) state_d = ST_SUM;
      ST_SUM:   if (last_col) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_EMIT;
      ST_EMIT:  if (!hit || slot_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= '0;
      seq_q       <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
      for (int i = 0; i < MAX_KMER_ORDER; i++) hist_q[i] <= '0;
      for (int i = 0; i < MAX_MOTIF_WIDTH; i++) win_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      seq_q       <= seq_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
      hist_q      <= hist_d;
      win_q       <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q      <= col_d;
    sum_q      <= sum_d;
    pend_bad_q <= pend_bad_d;
    res_q      <= res_d;
  end

  assign empty = !res_valid_q;
  assign out_o = res_q;

endmodule

### hw/rtl/pmst_checker.sv
// ----------------------------------------------------------------------------
// pmst_checker
// Port-level checks on the motif scan core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmst_checker import pmst_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input out_item_t   out_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_index_i,
  input logic [31:0] cfg_data_i
);

  logic signed [31:0] thr_q;
  logic               win_ok;

  // track the threshold as written through the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i == CFG_THRESHOLD)) begin
      thr_q <= cfg_data_i;
    end
  end

  assign win_ok = (out_o.start_pos != '0) && (out_o.stop_pos >= out_o.start_pos);

  `ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(out_o))
  `ASSERT_ALWAYS(a_hit_meets_thr, empty || (out_o.window_score >= thr_q))
  `ASSERT_ALWAYS(a_window_order, empty || win_ok)
  `ASSERT_NEXT(a_full_needs_push, !full && !push, !full)

endmodule

bind pwm_motif_scan_threshold_core pmst_checker u_checker (.*);
